// ===== rtl/core/sbfh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfh_pkg: shared types and constants for the segment/box face hit core
// Beat payloads, the classified-item record and axis/face codes.
// ----------------------------------------------------------------------------
package sbfh_pkg;

  localparam int COORD_W   = 32;
  localparam int RATIO_W   = 17;          // Q1.16 ratio, 65536 is one
  localparam int DIFF_W    = COORD_W + 1; // difference of two coordinates
  localparam int REM_W     = DIFF_W + 1;  // divider partial remainder
  localparam int PROD_W    = DIFF_W + RATIO_W + 1;
  localparam int WIDE_W    = COORD_W + 4; // interpolated point and compares
  localparam int DIV_STAGES = RATIO_W;    // one quotient bit per stage
  localparam int FRAC_BITS = 16;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [2:0] FACE_MIN_X = 3'd0;
  localparam logic [2:0] FACE_MAX_X = 3'd1;
  localparam logic [2:0] FACE_MIN_Z = 3'd2;
  localparam logic [2:0] FACE_MAX_Z = 3'd3;
  localparam logic [2:0] FACE_MIN_Y = 3'd4;
  localparam logic [2:0] FACE_MAX_Y = 3'd5;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
  } seg_t;

  typedef struct packed {
    logic                      hit;
    logic [2:0]                face_code;
    logic [RATIO_W-1:0]        hit_ratio;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
  } hit_t;

  // Item after face selection, indexed by axis (x, y, z).
  typedef struct packed {
    seg_t                    item;
    logic [2:0]              ok;
    logic [2:0]              sel;
    logic [2:0][DIFF_W-1:0]  num;
    logic [2:0][DIFF_W-1:0]  den;
  } cls_t;

  function automatic logic signed [COORD_W-1:0] axis_start(seg_t s, logic [1:0] a);
    logic signed [COORD_W-1:0] r;
    unique case (a)
      AX_X:    r = s.start_x;
      AX_Y:    r = s.start_y;
      default: r = s.start_z;
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] axis_end(seg_t s, logic [1:0] a);
    logic signed [COORD_W-1:0] r;
    unique case (a)
      AX_X:    r = s.end_x;
      AX_Y:    r = s.end_y;
      default: r = s.end_z;
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] axis_min(seg_t s, logic [1:0] a);
    logic signed [COORD_W-1:0] r;
    unique case (a)
      AX_X:    r = s.box_min_x;
      AX_Y:    r = s.box_min_y;
      default: r = s.box_min_z;
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] axis_max(seg_t s, logic [1:0] a);
    logic signed [COORD_W-1:0] r;
    unique case (a)
      AX_X:    r = s.box_max_x;
      AX_Y:    r = s.box_max_y;
      default: r = s.box_max_z;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/sbfh_front.sv =====
// ----------------------------------------------------------------------------
// sbfh_front: face selection
// Picks the candidate face on each axis and forms the ratio operands.
// ----------------------------------------------------------------------------
module sbfh_front (
  input  sbfh_pkg::seg_t seg,
  output sbfh_pkg::cls_t cls
);
  import sbfh_pkg::*;

  always_comb begin
    logic signed [DIFF_W-1:0] a0, a1, lo, hi;
    cls.item = seg;
    for (int a = 0; a < 3; a++) begin
      a0 = DIFF_W'(axis_start(seg, 2'(a)));
      a1 = DIFF_W'(axis_end(seg, 2'(a)));
      lo = DIFF_W'(axis_min(seg, 2'(a)));
      hi = DIFF_W'(axis_max(seg, 2'(a)));
      cls.sel[a] = 1'b0;
      cls.num[a] = '0;
      cls.den[a] = '0;
      cls.ok[a]  = 1'b0;
      if (a0 <= lo && a1 >= lo) begin
        cls.num[a] = lo - a0;
        cls.den[a] = a1 - a0;
        cls.ok[a]  = 1'b1;
      end else if (a0 >= hi && a1 <= hi) begin
        cls.sel[a] = 1'b1;
        cls.num[a] = a0 - hi;
        cls.den[a] = a0 - a1;
        cls.ok[a]  = 1'b1;
      end
      // A zero-length axis skips its face entirely.
      if (cls.den[a] == '0) cls.ok[a] = 1'b0;
    end
  end

endmodule

// ===== rtl/core/sbfh_fifo.sv =====
// ----------------------------------------------------------------------------
// sbfh_fifo: queue between face selection and the arithmetic pipeline
// Small register-based FIFO; full and empty come from an occupancy count.
// ----------------------------------------------------------------------------
module sbfh_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sbfh_pkg::cls_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output sbfh_pkg::cls_t rdata
);
  import sbfh_pkg::*;

  localparam int AW = $clog2(DEPTH);

  cls_t           mem [DEPTH];
  logic [AW-1:0]  wptr, rptr;
  logic [AW:0]    count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop && !empty) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

endmodule

// ===== rtl/core/sbfh_back.sv =====
// ----------------------------------------------------------------------------
// sbfh_back: ratio divider, interpolation and face priority
// Restoring divider with one quotient bit per stage on all three axes,
// a multiply stage for the interpolation and a check/select output stage.
// ----------------------------------------------------------------------------
module sbfh_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  input  sbfh_pkg::cls_t src,
  output logic           src_pop,
  output logic           hit_valid,
  input  logic           hit_ready,
  output sbfh_pkg::hit_t result
);
  import sbfh_pkg::*;

  typedef struct packed {
    seg_t                   item;
    logic [2:0]             ok;
    logic [2:0]             sel;
    logic [2:0][REM_W-1:0]  rem;
    logic [2:0][DIFF_W-1:0] den;
    logic [2:0][RATIO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    seg_t                         item;
    logic [2:0]                   ok;
    logic [2:0]                   sel;
    logic [2:0][RATIO_W-1:0]      ratio;
    logic [2:0][2:0][PROD_W-1:0]  prod;
  } mul_t;

  div_t                  dpipe [DIV_STAGES];
  div_t                  dnext [DIV_STAGES];
  logic [DIV_STAGES-1:0] dvld;
  mul_t                  mreg, mnext;
  logic                  mvld;
  hit_t                  rnext;
  logic                  adv;

  // The whole pipe moves together; it halts only when the result is stalled.
  assign adv       = !hit_valid || hit_ready;
  assign src_pop   = adv && src_valid;

  always_comb begin
    div_t                s;
    logic [REM_W-1:0]    t;
    logic [REM_W-1:0]    d;
    logic                ge;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        s.item = src.item;
        s.ok   = src.ok;
        s.sel  = src.sel;
        s.den  = src.den;
        s.quo  = '0;
        for (int a = 0; a < 3; a++) s.rem[a] = {1'b0, src.num[a]};
      end else begin
        s = dpipe[k-1];
      end
      dnext[k] = s;
      for (int a = 0; a < 3; a++) begin
        t  = (k == 0) ? s.rem[a] : {s.rem[a][REM_W-2:0], 1'b0};
        d  = {1'b0, s.den[a]};
        ge = (t >= d);
        dnext[k].rem[a] = ge ? t - d : t;
        dnext[k].quo[a] = {s.quo[a][RATIO_W-2:0], ge};
      end
    end
  end

  always_comb begin
    div_t                     s;
    logic signed [DIFF_W-1:0] delta;
    s          = dpipe[DIV_STAGES-1];
    mnext.item = s.item;
    mnext.ok   = s.ok;
    mnext.sel  = s.sel;
    mnext.ratio = s.quo;
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) begin
        delta = DIFF_W'(axis_end(s.item, 2'(i))) - DIFF_W'(axis_start(s.item, 2'(i)));
        if (i == a) mnext.prod[a][i] = '0;
        else mnext.prod[a][i] = PROD_W'(delta * $signed({1'b0, s.quo[a]}));
      end
    end
  end

  always_comb begin
    logic signed [WIDE_W-1:0]  v [3][3];
    logic [2:0]                pass;
    logic signed [WIDE_W-1:0]  lo, hi;
    logic signed [PROD_W-1:0]  p;
    for (int a = 0; a < 3; a++) begin
      pass[a] = mreg.ok[a];
      for (int i = 0; i < 3; i++) begin
        lo = WIDE_W'(axis_min(mreg.item, 2'(i)));
        hi = WIDE_W'(axis_max(mreg.item, 2'(i)));
        if (i == a) begin
          v[a][i] = mreg.sel[a] ? hi : lo;
        end else begin
          p = mreg.prod[a][i];
          // Arithmetic shift gives the floor toward minus infinity.
          v[a][i] = WIDE_W'(axis_start(mreg.item, 2'(i)))
                  + WIDE_W'($signed(p[PROD_W-1:FRAC_BITS]));
          if (v[a][i] < lo || v[a][i] > hi) pass[a] = 1'b0;
        end
      end
    end
    rnext = '0;
    priority if (pass[0]) begin
      rnext.hit       = 1'b1;
      rnext.face_code = mreg.sel[0] ? FACE_MAX_X : FACE_MIN_X;
      rnext.hit_ratio = mreg.ratio[0];
      rnext.hit_x = COORD_W'(v[0][0]);
      rnext.hit_y = COORD_W'(v[0][1]);
      rnext.hit_z = COORD_W'(v[0][2]);
    end else if (pass[2]) begin
      rnext.hit       = 1'b1;
      rnext.face_code = mreg.sel[2] ? FACE_MAX_Z : FACE_MIN_Z;
      rnext.hit_ratio = mreg.ratio[2];
      rnext.hit_x = COORD_W'(v[2][0]);
      rnext.hit_y = COORD_W'(v[2][1]);
      rnext.hit_z = COORD_W'(v[2][2]);
    end else if (pass[1]) begin
      rnext.hit       = 1'b1;
      rnext.face_code = mreg.sel[1] ? FACE_MAX_Y : FACE_MIN_Y;
      rnext.hit_ratio = mreg.ratio[1];
      rnext.hit_x = COORD_W'(v[1][0]);
      rnext.hit_y = COORD_W'(v[1][1]);
      rnext.hit_z = COORD_W'(v[1][2]);
    end else begin
      rnext = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_STAGES; k++) dpipe[k] <= dnext[k];
      mreg   <= mnext;
      result <= rnext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld      <= '0;
      mvld      <= 1'b0;
      hit_valid <= 1'b0;
    end else if (adv) begin
      dvld      <= {dvld[DIV_STAGES-2:0], src_valid};
      mvld      <= dvld[DIV_STAGES-1];
      hit_valid <= mvld;
    end
  end

endmodule

// ===== rtl/core/segment_box_face_hit_core.sv =====
// ----------------------------------------------------------------------------
// segment_box_face_hit_core: segment versus axis-aligned box entry face
// Top level: face selection, queue and arithmetic pipeline.
// ----------------------------------------------------------------------------
// One segment/box beat is taken per clock and one result beat leaves per
// clock in steady state. Between the queue and the result lie 17 divider
// stages, each resolving one ratio bit on all three axes and the first
// fed straight from the queue output, then the interpolation multiply
// and the check and select stage. Back-pressure on the result stalls the
// whole pipeline; the queue of FIFO_DEPTH beats then absorbs input until
// it fills.
module segment_box_face_hit_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           seg_valid,
  output logic           seg_ready,
  input  sbfh_pkg::seg_t seg,
  output logic           hit_valid,
  input  logic           hit_ready,
  output sbfh_pkg::hit_t result
);
  import sbfh_pkg::*;

  cls_t cls_in, cls_out;
  logic full, empty, pop;

  sbfh_front u_front (
    .seg (seg),
    .cls (cls_in)
  );

  sbfh_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (seg_valid),
    .wdata (cls_in),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .rdata (cls_out)
  );

  assign seg_ready = !full;

  sbfh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .src_valid (!empty),
    .src       (cls_out),
    .src_pop   (pop),
    .hit_valid (hit_valid),
    .hit_ready (hit_ready),
    .result    (result)
  );

endmodule

// ===== rtl/core/sbfh_check.sv =====
// ----------------------------------------------------------------------------
// sbfh_check: port-level checks for the face hit core
// Watches the result channel and the reset behavior.
// ----------------------------------------------------------------------------
module sbfh_check (
  input logic           clk,
  input logic           rst,
  input logic           hit_valid,
  input logic           hit_ready,
  input sbfh_pkg::hit_t result
);
  import sbfh_pkg::*;

  // A stalled result beat must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit_ready |=> hit_valid && $stable(result))
    else $error("result beat changed while stalled");

  // A miss reports all-zero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !result.hit |-> result.face_code == 3'd0 &&
      result.hit_ratio == '0 && result.hit_x == '0 &&
      result.hit_y == '0 && result.hit_z == '0)
    else $error("miss with nonzero fields");

  // A hit names a real face and a ratio no larger than one.
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    hit_valid && result.hit |-> result.face_code <= FACE_MAX_Y &&
      result.hit_ratio <= RATIO_ONE)
    else $error("hit fields out of range");

  // Nothing comes out in the cycle after reset.
  a_reset: assert property (@(posedge clk) rst |=> !hit_valid)
    else $error("result beat right after reset");

endmodule

bind segment_box_face_hit_core sbfh_check u_sbfh_check (.*);
